// File: rtl/mfe_pkg.sv
// shared constants, elaboration-time tables, types and state encoding for the mfcc extractor
package mfe_pkg;

  localparam int SAMPLE_RATE = 8000;
  localparam int FRAME_LEN   = 200;
  localparam int FRAME_STEP  = 80;
  localparam int NUM_FILTERS = 26;
  localparam int HALF_BINS   = FRAME_LEN / 2 + 1;
  localparam int DCT_PERIOD  = 4 * NUM_FILTERS;
  localparam int MAX_COEFFS  = 26;
  localparam int NC_RESET    = 13;

  localparam int RING_AW = $clog2(FRAME_LEN);
  localparam int BIN_AW  = $clog2(HALF_BINS);
  localparam int DCT_AW  = $clog2(DCT_PERIOD);
  localparam int FILT_AW = $clog2(NUM_FILTERS);
  localparam int EDGE_AW = $clog2(NUM_FILTERS + 2);
  localparam int FILL_W  = $clog2(FRAME_LEN + 1);
  localparam int STEP_W  = $clog2(FRAME_STEP + 1);
  localparam int COEF_W  = 5;
  localparam int W_W     = 17;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [23:0] LN2_Q24     = 24'd11629080;

  typedef logic [FRAME_LEN-1:0][31:0]          dft_tab_t;
  typedef logic [DCT_PERIOD-1:0][31:0]         dct_tab_t;
  typedef logic [NUM_FILTERS+1:0][BIN_AW-1:0]  edge_tab_t;
  typedef logic [HALF_BINS-1:0][W_W-1:0]       wt_tab_t;

  // restoring divider, used only while building constant tables
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series cos/sin in q30 with quadrant mapping
  function automatic longint trig_q30(input longint m, input longint period, input bit want_sin);
    logic [63:0] q4, r, th, th2, term;
    longint ca, sa, c, s;
    q4 = udiv(64'(4 * m), 64'(period));
    r = 64'(4 * m) - q4 * 64'(period);
    th = udiv(HALF_PI_Q30 * r, 64'(period));
    th2 = (th * th) >> 30;
    term = ONE_Q30;
    ca = longint'(ONE_Q30);
    for (int i = 1; i <= 8; i++) begin
      term = udiv((term * th2) >> 30, 64'((2 * i - 1) * (2 * i)));
      if ((i & 1) == 1) ca = ca - longint'(term);
      else ca = ca + longint'(term);
    end
    term = th;
    sa = longint'(th);
    for (int i = 1; i <= 8; i++) begin
      term = udiv((term * th2) >> 30, 64'((2 * i) * (2 * i + 1)));
      if ((i & 1) == 1) sa = sa - longint'(term);
      else sa = sa + longint'(term);
    end
    if (ca < 0) ca = 0;
    if (ca > longint'(ONE_Q30)) ca = longint'(ONE_Q30);
    if (sa < 0) sa = 0;
    if (sa > longint'(ONE_Q30)) sa = longint'(ONE_Q30);
    case (q4[1:0])
      2'd0: begin c = ca;  s = sa;  end
      2'd1: begin c = -sa; s = ca;  end
      2'd2: begin c = -ca; s = -sa; end
      default: begin c = sa; s = -ca; end
    endcase
    return want_sin ? s : c;
  endfunction

  // log2 in q32 by repeated squaring of a q31 mantissa
  function automatic logic [63:0] lg_q32(input logic [63:0] x);
    logic [63:0] y, frac;
    int n;
    n = 0;
    frac = '0;
    for (int b = 0; b < 64; b++) begin
      if (x[b]) n = b;
    end
    if (n >= 31) y = x >> (n - 31);
    else y = x << (31 - n);
    for (int b = 31; b >= 0; b--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[b] = 1'b1;
      end
    end
    return (x == '0) ? 64'd0 : ((64'(n) << 32) | frac);
  endfunction

  function automatic edge_tab_t build_edges();
    edge_tab_t e;
    longint base, span, bm;
    int count;
    base = longint'(lg_q32(64'(1000 * (FRAME_LEN + 1))));
    span = longint'(lg_q32(64'd4100)) - longint'(lg_q32(64'd1000));
    for (int i = 0; i < NUM_FILTERS + 2; i++) begin
      count = 0;
      for (int j = 0; j < HALF_BINS; j++) begin
        bm = longint'(NUM_FILTERS + 1) * (longint'(lg_q32(64'(700 * (FRAME_LEN + 1))
             + 64'(j) * 64'(SAMPLE_RATE))) - base);
        if (bm <= longint'(i) * span) count++;
      end
      e[i] = BIN_AW'((count > 0) ? count - 1 : 0);
    end
    return e;
  endfunction

  localparam edge_tab_t BAND_EDGE = build_edges();

  // weight of each bin within the edge segment that holds it
  function automatic wt_tab_t build_weights(input bit falling);
    wt_tab_t w;
    int lo, hi;
    for (int j = 0; j < HALF_BINS; j++) begin
      w[j] = '0;
      for (int s = 0; s <= NUM_FILTERS; s++) begin
        lo = int'(BAND_EDGE[s]);
        hi = int'(BAND_EDGE[s+1]);
        if (j >= lo && j < hi) begin
          if (falling) w[j] = W_W'(udiv(64'(hi - j) << 16, 64'(hi - lo)));
          else w[j] = W_W'(udiv(64'(j - lo) << 16, 64'(hi - lo)));
        end
      end
    end
    return w;
  endfunction

  function automatic dft_tab_t build_dft(input bit want_sin);
    dft_tab_t t;
    for (int i = 0; i < FRAME_LEN; i++) t[i] = 32'(trig_q30(i, FRAME_LEN, want_sin));
    return t;
  endfunction

  function automatic dct_tab_t build_dct();
    dct_tab_t t;
    for (int i = 0; i < DCT_PERIOD; i++) t[i] = 32'(trig_q30(i, DCT_PERIOD, 1'b0));
    return t;
  endfunction

  localparam wt_tab_t  RISE_W  = build_weights(1'b0);
  localparam wt_tab_t  FALL_W  = build_weights(1'b1);
  localparam dft_tab_t DFT_COS = build_dft(1'b0);
  localparam dft_tab_t DFT_SIN = build_dft(1'b1);
  localparam dct_tab_t DCT_COS = build_dct();

  typedef enum logic [4:0] {
    S_IDLE, S_DFT_INIT, S_DFT_C, S_DFT_S, S_DFT_TAIL, S_PWR_RE, S_PWR_IM, S_PWR_WR,
    S_FB_INIT, S_FB_RD, S_FB_M0, S_FB_M1, S_FB_M2, S_FB_ACC, S_FB_ADD,
    S_LG_LOAD, S_LG_NORM, S_LG_SQ, S_LG_CHK, S_LE_M0, S_LE_M1, S_LE_M2, S_LE_WR,
    S_DC_INIT, S_DC_RD, S_DC_MUL, S_DC_ACC, S_DC_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic                ring_we;
    logic [RING_AW-1:0]  ring_waddr;
    logic signed [15:0]  ring_wdata;
    logic [COEF_W-1:0]   nc_last;
    logic                res_take;
  } core_ctl_t;

  typedef struct packed {
    logic                busy;
    logic                res_valid;
    logic signed [31:0]  coeff;
    logic [COEF_W-1:0]   coeff_index;
    logic                last;
  } core_stat_t;

endpackage

// File: rtl/mfcc_frame_extractor.sv
// mfcc frame extractor: sample intake, framing counters, config register and result register
// a sample is accepted whenever no frame is running; the work of a frame is set by the dft loop
// (a cosine and a sine product on the shared multiplier per sample per bin, 101 bins)
// plus filterbank, log and dct passes on the same multiplier
// coefficients leave through a one-entry output register; samples stall while a frame runs
// synchronous active-high reset clears counters, the frame number and sets num_coeffs to 13
module mfcc_frame_extractor import mfe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output logic               coeff_valid,
  input  logic               coeff_stall,
  output logic signed [31:0] coeff,
  output logic [4:0]         coeff_index,
  output logic [15:0]        frame_index,
  output logic               last_of_frame
);

  core_ctl_t  ctl;
  core_stat_t stat;

  logic [4:0]         num_coeffs;
  logic [FILL_W-1:0]  fill;
  logic [STEP_W-1:0]  step;
  logic [RING_AW-1:0] wpos;
  logic [15:0]        frame_counter;
  logic               sample_acc, trig, out_take;
  logic [COEF_W-1:0]  nc_last;

  mfe_core u_core (.clk(clk), .rst(rst), .ctl(ctl), .stat(stat));

  assign cfg_ready    = 1'b1;
  assign sample_stall = stat.busy;
  assign sample_acc   = sample_valid & ~sample_stall;
  assign out_take     = coeff_valid & ~coeff_stall;

  always_comb begin
    if (fill != FILL_W'(FRAME_LEN)) trig = (fill == FILL_W'(FRAME_LEN - 1));
    else trig = (step == STEP_W'(FRAME_STEP - 1));
    if (num_coeffs == '0) nc_last = '0;
    else if (num_coeffs > COEF_W'(MAX_COEFFS)) nc_last = COEF_W'(MAX_COEFFS - 1);
    else nc_last = num_coeffs - 1'b1;
    ctl.start      = sample_acc & trig;
    ctl.ring_we    = sample_acc;
    ctl.ring_waddr = wpos;
    ctl.ring_wdata = sample;
    ctl.nc_last    = nc_last;
    ctl.res_take   = stat.res_valid & (~coeff_valid | ~coeff_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_coeffs <= COEF_W'(NC_RESET);
    end else if (cfg_valid && cfg_ready) begin
      num_coeffs <= cfg_data;
    end
  end

  // framing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      step <= '0;
      wpos <= '0;
    end else if (sample_acc) begin
      wpos <= (wpos == RING_AW'(FRAME_LEN - 1)) ? '0 : wpos + 1'b1;
      if (fill != FILL_W'(FRAME_LEN)) fill <= fill + 1'b1;
      if (trig) step <= '0;
      else if (fill == FILL_W'(FRAME_LEN)) step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_valid   <= 1'b0;
      frame_counter <= '0;
    end else begin
      if (ctl.res_take) coeff_valid <= 1'b1;
      else if (out_take) coeff_valid <= 1'b0;
      if (ctl.res_take && stat.last) frame_counter <= frame_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_take) begin
      coeff         <= stat.coeff;
      coeff_index   <= stat.coeff_index;
      frame_index   <= frame_counter;
      last_of_frame <= stat.last;
    end
  end

endmodule

// File: rtl/mfe_mul.sv
// shared registered 33x33 signed multiplier
module mfe_mul import mfe_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/mfe_core.sv
// frame sequencer: dft power spectrum, mel filterbank, log and dct on one shared multiplier
module mfe_core import mfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_ctl_t  ctl,
  output core_stat_t stat
);

  state_t state, state_next;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        prod;

  // dft
  logic [RING_AW-1:0] n, n_next, t, t_next;
  logic [RING_AW:0]   tsum;
  logic [BIN_AW-1:0]  k;
  logic signed [63:0] re, im, re_sh, im_sh;
  logic [63:0]        pwr;
  logic signed [15:0] ring [FRAME_LEN];
  logic signed [15:0] ring_q;
  logic signed [31:0] tw_c_q, tw_s_q;

  // filterbank
  logic [63:0]        pmem [HALF_BINS];
  logic [63:0]        pmem_q;
  logic [W_W-1:0]     w_q;
  logic [FILT_AW-1:0] filt;
  logic [BIN_AW-1:0]  bin;
  logic [BIN_AW:0]    bin_inc;
  logic [BIN_AW-1:0]  e0, e1, e2;
  logic [63:0]        bacc, tacc;
  logic [64:0]        bsum;

  // log
  logic [63:0] x;
  logic [5:0]  nlg;
  logic [31:0] y, frac;
  logic [4:0]  bcnt;
  logic [32:0] y2;
  logic [37:0] d;

  // dct
  logic [31:0]        lemem [NUM_FILTERS];
  logic [31:0]        le_q;
  logic signed [31:0] dcos_q;
  logic [COEF_W-1:0]  kc, nc_last;
  logic [FILT_AW-1:0] nd;
  logic [DCT_AW-1:0]  td;
  logic [DCT_AW:0]    tdsum;
  logic signed [63:0] dacc, rnd;
  logic signed [31:0] coeff_sat;

  mfe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign prod    = mul_p[63:0];
  assign re_sh   = re >>> 26;
  assign im_sh   = im >>> 26;
  assign e0      = BAND_EDGE[EDGE_AW'(filt)];
  assign e1      = BAND_EDGE[EDGE_AW'(filt) + EDGE_AW'(1)];
  assign e2      = BAND_EDGE[EDGE_AW'(filt) + EDGE_AW'(2)];
  assign bin_inc = {1'b0, bin} + 1'b1;
  assign bsum    = {1'b0, bacc} + {1'b0, tacc};
  assign y2      = prod[63:31];
  assign d       = {nlg - 6'd8, frac};
  assign tsum    = {1'b0, t} + (RING_AW+1)'(k);
  assign tdsum   = {1'b0, td} + (DCT_AW+1)'({kc, 1'b0});
  assign rnd     = (dacc + (64'sd1 <<< 29)) >>> 30;

  always_comb begin
    if (rnd > 64'sd2147483647) coeff_sat = 32'sh7fffffff;
    else if (rnd < -64'sd2147483648) coeff_sat = 32'sh80000000;
    else coeff_sat = rnd[31:0];
  end

  // window index and twiddle index advance together
  always_comb begin
    n_next = n;
    t_next = t;
    unique case (state)
      S_DFT_INIT: begin
        n_next = '0;
        t_next = '0;
      end
      S_DFT_S: begin
        n_next = (n == RING_AW'(FRAME_LEN - 1)) ? '0 : n + 1'b1;
        t_next = (tsum >= (RING_AW+1)'(FRAME_LEN)) ? RING_AW'(tsum - (RING_AW+1)'(FRAME_LEN))
                                                   : tsum[RING_AW-1:0];
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (ctl.start) state_next = S_DFT_INIT;
      S_DFT_INIT: state_next = S_DFT_C;
      S_DFT_C:    state_next = S_DFT_S;
      S_DFT_S:    state_next = (n == RING_AW'(FRAME_LEN - 1)) ? S_DFT_TAIL : S_DFT_C;
      S_DFT_TAIL: state_next = S_PWR_RE;
      S_PWR_RE:   state_next = S_PWR_IM;
      S_PWR_IM:   state_next = S_PWR_WR;
      S_PWR_WR:   state_next = (k == BIN_AW'(HALF_BINS - 1)) ? S_FB_INIT : S_DFT_INIT;
      S_FB_INIT:  state_next = (e0 < e2) ? S_FB_RD : S_LG_LOAD;
      S_FB_RD:    state_next = S_FB_M0;
      S_FB_M0:    state_next = S_FB_M1;
      S_FB_M1:    state_next = S_FB_M2;
      S_FB_M2:    state_next = S_FB_ACC;
      S_FB_ACC:   state_next = S_FB_ADD;
      S_FB_ADD:   state_next = (bin_inc < {1'b0, e2}) ? S_FB_RD : S_LG_LOAD;
      S_LG_LOAD:  state_next = S_LG_NORM;
      S_LG_NORM:  if (x[63]) state_next = S_LG_SQ;
      S_LG_SQ:    state_next = S_LG_CHK;
      S_LG_CHK:   state_next = (bcnt == '0) ? S_LE_M0 : S_LG_SQ;
      S_LE_M0:    state_next = S_LE_M1;
      S_LE_M1:    state_next = S_LE_M2;
      S_LE_M2:    state_next = S_LE_WR;
      S_LE_WR:    state_next = (filt == FILT_AW'(NUM_FILTERS - 1)) ? S_DC_INIT : S_FB_INIT;
      S_DC_INIT:  state_next = S_DC_RD;
      S_DC_RD:    state_next = S_DC_MUL;
      S_DC_MUL:   state_next = S_DC_ACC;
      S_DC_ACC:   state_next = (nd == FILT_AW'(NUM_FILTERS - 1)) ? S_DC_OUT : S_DC_RD;
      S_DC_OUT: begin
        if (ctl.res_take) state_next = (kc == nc_last) ? S_IDLE : S_DC_INIT;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // multiplier operands and status
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DFT_C: begin
        mul_a = {{17{ring_q[15]}}, ring_q};
        mul_b = {tw_c_q[31], tw_c_q};
      end
      S_DFT_S: begin
        mul_a = {{17{ring_q[15]}}, ring_q};
        mul_b = {tw_s_q[31], tw_s_q};
      end
      S_PWR_RE: begin
        mul_a = re_sh[32:0];
        mul_b = re_sh[32:0];
      end
      S_PWR_IM: begin
        mul_a = im_sh[32:0];
        mul_b = im_sh[32:0];
      end
      S_FB_M0: begin
        mul_a = {1'b0, pmem_q[63:32]};
        mul_b = {16'b0, w_q};
      end
      S_FB_M1: begin
        mul_a = {17'b0, pmem_q[31:16]};
        mul_b = {16'b0, w_q};
      end
      S_FB_M2: begin
        mul_a = {17'b0, pmem_q[15:0]};
        mul_b = {16'b0, w_q};
      end
      S_LG_SQ: begin
        mul_a = {1'b0, y};
        mul_b = {1'b0, y};
      end
      S_LE_M0: begin
        mul_a = {11'b0, d[37:16]};
        mul_b = {9'b0, LN2_Q24};
      end
      S_LE_M1: begin
        mul_a = {17'b0, d[15:0]};
        mul_b = {9'b0, LN2_Q24};
      end
      S_DC_MUL: begin
        mul_a = {1'b0, le_q};
        mul_b = {dcos_q[31], dcos_q};
      end
      default: ;
    endcase
    stat.busy        = (state != S_IDLE);
    stat.res_valid   = (state == S_DC_OUT);
    stat.coeff       = coeff_sat;
    stat.coeff_index = kc;
    stat.last        = (kc == nc_last);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // memories and table reads
  always_ff @(posedge clk) begin
    if (ctl.ring_we) ring[ctl.ring_waddr] <= ctl.ring_wdata;
    ring_q <= ring[n_next];
    tw_c_q <= DFT_COS[t_next];
    tw_s_q <= DFT_SIN[t_next];
  end

  always_ff @(posedge clk) begin
    if (state == S_PWR_WR) pmem[k] <= pwr + prod;
    pmem_q <= pmem[bin];
    w_q    <= (bin < e1) ? RISE_W[bin] : FALL_W[bin];
  end

  always_ff @(posedge clk) begin
    if (state == S_LE_WR) lemem[filt] <= {8'b0, tacc[63:40]};
    le_q   <= lemem[nd];
    dcos_q <= DCT_COS[td];
  end

  // datapath
  always_ff @(posedge clk) begin
    n <= n_next;
    t <= t_next;
    unique case (state)
      S_IDLE: begin
        k       <= '0;
        kc      <= '0;
        nc_last <= ctl.nc_last;
      end
      S_DFT_INIT: begin
        re <= '0;
        im <= '0;
      end
      S_DFT_C:    if (n != '0) im <= im - $signed(prod);
      S_DFT_S:    re <= re + $signed(prod);
      S_DFT_TAIL: im <= im - $signed(prod);
      S_PWR_IM:   pwr <= prod;
      S_PWR_WR: begin
        k    <= k + 1'b1;
        filt <= '0;
      end
      S_FB_INIT: begin
        bin  <= e0;
        bacc <= '0;
      end
      S_FB_M1:  tacc <= prod << 16;
      S_FB_M2:  tacc <= tacc + prod;
      S_FB_ACC: tacc <= tacc + (prod >> 16);
      S_FB_ADD: begin
        bacc <= bsum[64] ? '1 : bsum[63:0];
        bin  <= bin_inc[BIN_AW-1:0];
      end
      S_LG_LOAD: begin
        x   <= (bacc < 64'd256) ? 64'd256 : bacc;
        nlg <= 6'd63;
      end
      S_LG_NORM: begin
        if (x[63]) begin
          y    <= x[63:32];
          frac <= '0;
          bcnt <= 5'd31;
        end else begin
          x   <= x << 1;
          nlg <= nlg - 1'b1;
        end
      end
      S_LG_CHK: begin
        if (y2[32]) begin
          y          <= y2[32:1];
          frac[bcnt] <= 1'b1;
        end else begin
          y <= y2[31:0];
        end
        bcnt <= bcnt - 1'b1;
      end
      S_LE_M1: tacc <= prod << 16;
      S_LE_M2: tacc <= tacc + prod;
      S_LE_WR: filt <= filt + 1'b1;
      S_DC_INIT: begin
        nd   <= '0;
        td   <= DCT_AW'(kc);
        dacc <= '0;
      end
      S_DC_ACC: begin
        dacc <= dacc + $signed(prod);
        nd   <= nd + 1'b1;
        td   <= (tdsum >= (DCT_AW+1)'(DCT_PERIOD)) ? DCT_AW'(tdsum - (DCT_AW+1)'(DCT_PERIOD))
                                                  : tdsum[DCT_AW-1:0];
      end
      S_DC_OUT: if (ctl.res_take) kc <= kc + 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/mfe_check.sv
// port-level checks for the mfcc frame extractor, bound to the top level
module mfe_check (
  input logic               clk,
  input logic               rst,
  input logic               sample_stall,
  input logic               coeff_valid,
  input logic               coeff_stall,
  input logic signed [31:0] coeff,
  input logic [4:0]         coeff_index,
  input logic [15:0]        frame_index,
  input logic               last_of_frame
);

  // a stalled transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    coeff_valid && coeff_stall |=> coeff_valid && $stable(coeff) && $stable(coeff_index)
      && $stable(frame_index) && $stable(last_of_frame))
    else $error("stalled coefficient changed");

  a_index: assert property (@(posedge clk) disable iff (rst)
    coeff_valid |-> coeff_index <= 5'd25)
    else $error("coefficient index out of range");

  // after a coefficient that is not the last, either the frame is still being worked on
  // or its last coefficient has just moved into the output register
  a_busy: assert property (@(posedge clk) disable iff (rst)
    coeff_valid && !coeff_stall && !last_of_frame |=>
      sample_stall || (coeff_valid && last_of_frame))
    else $error("block idle in the middle of a frame");

  a_rst: assert property (@(posedge clk) rst |=> !coeff_valid)
    else $error("result valid after reset");

endmodule

bind mfcc_frame_extractor mfe_check u_check (.*);
